// File: rtl/idr_pkg.sv
// Package for the 32/64-bit integer divider: payload structs, opcode names,
// and the pipeline record passed between front, queue and back stages.
// No dependencies.
`default_nettype none
package idr_pkg;

    localparam int unsigned DataW  = 64;
    localparam int unsigned NarrowW = 32;
    localparam int unsigned QDepth = 2;
    localparam int unsigned QPtrW  = 1;
    localparam int unsigned QCntW  = 2;

    typedef enum logic [1:0] {
        OP_S32 = 2'd0,
        OP_U32 = 2'd1,
        OP_S64 = 2'd2,
        OP_U64 = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [DataW-1:0]  dividend;
        logic [DataW-1:0]  divisor;
    } in_item_t;

    typedef struct packed {
        logic [DataW-1:0]  quotient;
        logic [DataW-1:0]  remainder_out;
        logic              zero_divisor;
    } out_item_t;

    // Classified operation handed from the front to the back.
    typedef struct packed {
        logic              wide;
        logic              neg_q;
        logic              neg_r;
        logic              zero_div;
        logic [DataW-1:0]  num;
        logic [DataW-1:0]  den;
    } work_t;

    // One row of the restoring array.
    typedef struct packed {
        logic              wide;
        logic              neg_q;
        logic              neg_r;
        logic              zero_div;
        logic [DataW-1:0]  num;
        logic [DataW-1:0]  den;
        logic [DataW-1:0]  rem;
        logic [DataW-1:0]  quo;
    } row_t;

endpackage
`default_nettype wire

// File: rtl/idr_front.sv
// Front stage: masks operands to the mode width, takes magnitudes and
// records result signs. Depends on idr_pkg.
`default_nettype none
module idr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire idr_pkg::in_item_t in_item,
    output logic                   in_ready,
    output logic                   out_valid,
    output idr_pkg::work_t         out_work,
    input  wire logic              out_ready
);
    import idr_pkg::*;

    logic             valid_reg;
    work_t            work_reg;
    work_t            work_next;
    logic             wide;
    logic             sgn;
    logic [DataW-1:0] mask;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic             a_neg;
    logic             b_neg;
    logic [DataW-1:0] a_abs;
    logic [DataW-1:0] b_abs;

    // Operand classification.
    always_comb
    begin
        wide  = (in_item.opcode == OP_S64) || (in_item.opcode == OP_U64);
        sgn   = (in_item.opcode == OP_S64) || (in_item.opcode == OP_S32);
        mask  = wide ? '1 : {{(DataW-NarrowW){1'b0}}, {NarrowW{1'b1}}};
        a     = in_item.dividend & mask;
        b     = in_item.divisor & mask;
        a_neg = sgn && (wide ? a[DataW-1] : a[NarrowW-1]);
        b_neg = sgn && (wide ? b[DataW-1] : b[NarrowW-1]);
        a_abs = a_neg ? ((~a + 1'b1) & mask) : a;
        b_abs = b_neg ? ((~b + 1'b1) & mask) : b;
        work_next.wide     = wide;
        work_next.neg_q    = a_neg != b_neg;
        work_next.neg_r    = a_neg;
        work_next.zero_div = (b == '0);
        work_next.num      = wide ? a_abs : {a_abs[NarrowW-1:0], {NarrowW{1'b0}}};
        work_next.den      = b_abs;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            work_reg <= work_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/idr_queue.sv
// Short queue decoupling the front from the back.
// Depends on idr_pkg.
`default_nettype none
module idr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    input  wire idr_pkg::work_t wr_data,
    output logic                wr_ready,
    output logic                rd_valid,
    output idr_pkg::work_t      rd_data,
    input  wire logic           rd_ready
);
    import idr_pkg::*;

    work_t            mem_reg [QDepth];
    logic [QPtrW-1:0] wptr_reg;
    logic [QPtrW-1:0] rptr_reg;
    logic [QCntW-1:0] cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = cnt_reg != QCntW'(QDepth);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + QCntW'(do_wr) - QCntW'(do_rd);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/idr_back.sv
// Back stage: 64-row restoring divide array, one row per pipeline stage,
// then sign fix-up and a two-entry result queue. Depends on idr_pkg.
`default_nettype none
module idr_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire idr_pkg::work_t     in_work,
    output logic                    in_ready,
    output logic                    empty,
    output idr_pkg::out_item_t      result,
    input  wire logic               pop
);
    import idr_pkg::*;

    localparam int unsigned Stages = DataW;

    row_t       row_reg   [Stages+1];
    logic       vld_reg   [Stages+1];
    row_t       row_next  [Stages+1];
    logic       advance;
    logic [1:0] res_cnt_reg;
    logic [1:0] inflight;
    out_item_t  fix;
    out_item_t  res_reg [2];
    logic       res_wptr_reg;
    logic       res_rptr_reg;
    logic       do_pop;
    logic       do_push;
    logic [DataW-1:0] qm;
    logic [DataW-1:0] rm;

    // The array moves as one. It stalls only when its last row holds a
    // result while the result queue is full and nothing is popped.
    assign do_pop  = !empty && pop;
    assign do_push = vld_reg[Stages] && advance;
    assign inflight = res_cnt_reg;
    assign advance = !vld_reg[Stages] || (inflight != 2'd2) || do_pop;
    assign in_ready = advance;
    assign empty   = res_cnt_reg == 2'd0;
    assign result  = res_reg[res_rptr_reg];

    // Row 0 is the incoming work item.
    always_comb
    begin
        row_next[0].wide     = in_work.wide;
        row_next[0].neg_q    = in_work.neg_q;
        row_next[0].neg_r    = in_work.neg_r;
        row_next[0].zero_div = in_work.zero_div;
        row_next[0].num      = in_work.num;
        row_next[0].den      = in_work.den;
        row_next[0].rem      = '0;
        row_next[0].quo      = '0;
    end

    // One shift-subtract step per row.
    for (genvar s = 1; s <= Stages; s++)
    begin : g_row
        logic             carry;
        logic [DataW-1:0] sh;
        logic [DataW:0]   diff;
        logic             take;
        always_comb
        begin
            carry = row_reg[s-1].rem[DataW-1];
            sh    = {row_reg[s-1].rem[DataW-2:0], row_reg[s-1].num[DataW-1]};
            diff  = {1'b0, sh} - {1'b0, row_reg[s-1].den};
            take  = carry || !diff[DataW];
            // Narrow items skip the first 32 steps with zero dividend bits.
            row_next[s]     = row_reg[s-1];
            row_next[s].num = {row_reg[s-1].num[DataW-2:0], 1'b0};
            if (!row_reg[s-1].wide && (s <= NarrowW))
            begin
                row_next[s].num = row_reg[s-1].num;
            end
            else
            begin
                row_next[s].rem = take ? diff[DataW-1:0] : sh;
                row_next[s].quo = {row_reg[s-1].quo[DataW-2:0], take};
            end
        end
    end

    // Array registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= Stages; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= Stages; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i <= Stages; i++)
            begin
                row_reg[i] <= row_next[i];
            end
        end
    end

    // Sign fix-up of the last row.
    always_comb
    begin
        qm = row_reg[Stages].neg_q ? (~row_reg[Stages].quo + 1'b1) : row_reg[Stages].quo;
        rm = row_reg[Stages].neg_r ? (~row_reg[Stages].rem + 1'b1) : row_reg[Stages].rem;
        if (!row_reg[Stages].wide)
        begin
            qm[DataW-1:NarrowW] = '0;
            rm[DataW-1:NarrowW] = '0;
        end
        fix.quotient      = row_reg[Stages].zero_div ? '0 : qm;
        fix.remainder_out = row_reg[Stages].zero_div ? '0 : rm;
        fix.zero_divisor  = row_reg[Stages].zero_div;
    end

    // Result queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg  <= '0;
            res_wptr_reg <= 1'b0;
            res_rptr_reg <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                res_wptr_reg <= !res_wptr_reg;
            end
            if (do_pop)
            begin
                res_rptr_reg <= !res_rptr_reg;
            end
            res_cnt_reg <= res_cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            res_reg[res_wptr_reg] <= fix;
        end
    end

endmodule
`default_nettype wire

// File: rtl/int_divide_remainder_32_64.sv
// Top level of the 32/64-bit signed/unsigned integer divider.
// Depends on idr_pkg, idr_front, idr_queue and idr_back.
//
//   channel   handshake        payload
//   input     push / full      in_item  (opcode, dividend, divisor)
//   result    pop / empty      out_item (quotient, remainder_out, zero_divisor)
//
// With no stalls, a transaction passes in order through the front register,
// the queue storage, the 65 array row registers and the result queue entry.
// One transaction enters per cycle unless stalled, since every array row is
// its own pipeline stage. Reset clears all valid state at once. A full result
// queue stalls the array, and the short middle queue absorbs the front meanwhile.
`default_nettype none
module int_divide_remainder_32_64 (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire idr_pkg::in_item_t  in_item,
    output logic                    empty,
    input  wire logic               pop,
    output idr_pkg::out_item_t      out_item
);
    import idr_pkg::*;

    logic  f_ready;
    logic  f_valid;
    work_t f_work;
    logic  q_ready;
    logic  q_valid;
    work_t q_work;
    logic  b_ready;

    assign full = !f_ready;

    idr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_item   (in_item),
        .in_ready  (f_ready),
        .out_valid (f_valid),
        .out_work  (f_work),
        .out_ready (q_ready)
    );

    idr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_data  (f_work),
        .wr_ready (q_ready),
        .rd_valid (q_valid),
        .rd_data  (q_work),
        .rd_ready (b_ready)
    );

    idr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_work  (q_work),
        .in_ready (b_ready),
        .empty    (empty),
        .result   (out_item),
        .pop      (pop)
    );

    // A zero-divisor result carries zero quotient and remainder.
    a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.zero_divisor) |-> (out_item.quotient == '0 &&
        out_item.remainder_out == '0))
        else $error("zero divisor result not cleared");

    // A result that is not popped stays in place.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("waiting result changed");

    // Reset leaves the result queue empty.
    a_empty_reset: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result present right after reset");

endmodule
`default_nettype wire
